/* sv/dual_channel_dimmer_key_slider_ramp_defines.svh */
// Assertion macros shared by the dimmer checker.
`ifndef DUAL_CHANNEL_DIMMER_KEY_SLIDER_RAMP_DEFINES_SVH
`define DUAL_CHANNEL_DIMMER_KEY_SLIDER_RAMP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define DCDK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define DCDK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dcdksr_pkg.sv */
// Types, register indexes and the level table of the dual channel dimmer.
package dcdksr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_SCALE   = 3'd0,
        REG_RAMP_STEPS  = 3'd1,
        REG_BLOCK_TICKS = 3'd2,
        REG_SEND_PERIOD = 3'd3,
        REG_MIN_LEVEL   = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] SLIDER_MAX     = 8'd127;
    localparam logic [6:0] PCT_LO         = 7'd10;
    localparam logic [6:0] PCT_SPAN       = 7'd90;
    localparam logic [7:0] LEVEL_RESET    = 8'd254;
    localparam logic [7:0] RST_BLOCK      = 8'd25;
    localparam logic [7:0] RST_MIN_LEVEL  = 8'd170;
    localparam logic [3:0] RST_RAMP       = 4'd2;
    localparam logic [7:0] RST_SEND       = 8'd1;

    localparam logic [2:0] KEY_BOTTOM = 3'b001;
    localparam logic [2:0] KEY_MIDDLE = 3'b010;
    localparam logic [2:0] KEY_TOP    = 3'b100;

    // Percent to level, 0 to 100 percent.
    localparam logic [7:0] PCT_LEVEL [0:100] = '{
          8'd0,  8'd85, 8'd111, 8'd126, 8'd136, 8'd144, 8'd151, 8'd157, 8'd161, 8'd166,
        8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd189, 8'd191, 8'd193,
        8'd195, 8'd197, 8'd199, 8'd200, 8'd202, 8'd203, 8'd205, 8'd206, 8'd207, 8'd209,
        8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd216, 8'd217, 8'd218, 8'd219, 8'd220,
        8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd226, 8'd227, 8'd228,
        8'd229, 8'd229, 8'd230, 8'd231, 8'd231, 8'd232, 8'd233, 8'd233, 8'd234, 8'd235,
        8'd235, 8'd236, 8'd236, 8'd237, 8'd238, 8'd238, 8'd239, 8'd239, 8'd240, 8'd240,
        8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
        8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250,
        8'd250, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254,
        8'd254
    };

    typedef struct packed {
        logic       key_event;
        logic [2:0] keys_pressed;
        logic       slider_bottom_event;
        logic [7:0] slider_bottom_value;
        logic       slider_top_event;
        logic [7:0] slider_top_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] level_bottom;
        logic [7:0] level_top;
        logic       relay_bottom;
        logic       relay_top;
        logic [1:0] on_status;
        logic [2:0] toggle_states;
        logic       send_strobe;
    } out_item_t;

endpackage

/* sv/dual_channel_dimmer_key_slider_ramp.sv */
// Dual channel dimmer: keys, sliders, level ramps, relays and send strobe.
// Each accepted item's result is registered into the output buffer.
// Throughput: one item per cycle while the skid entry is empty; the whole tick is
// one pass of logic into the state. A two-entry output buffer keeps input flowing
// while one result waits. Reset: all but the output data registers take their reset values; no clearing pass.
module dual_channel_dimmer_key_slider_ramp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dcdksr_pkg::in_item_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output dcdksr_pkg::out_item_t              out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dcdksr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcdksr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcdksr_pkg::*;

    // Configuration registers.
    logic       log_scale_reg;
    logic [3:0] ramp_steps_reg;
    logic [7:0] block_ticks_reg;
    logic [7:0] send_period_reg;
    logic [7:0] min_level_reg;

    // Tick state.
    logic [2:0] toggle_reg, toggle_next;
    logic [7:0] timer_b_reg, timer_b_next;
    logic [7:0] timer_t_reg, timer_t_next;
    logic [1:0] on_reg, on_next;
    logic       en_b_reg, en_b_next;
    logic       en_t_reg, en_t_next;
    logic [7:0] target_b_reg, target_b_next;
    logic [7:0] target_t_reg, target_t_next;
    logic [7:0] lvl_b_reg, lvl_b_next;
    logic [7:0] lvl_t_reg, lvl_t_next;
    logic [1:0] relay_reg, relay_next;
    logic [7:0] send_cnt_reg, send_cnt_next;
    logic       strobe;

    // Output buffer.
    out_item_t  out_reg, skid_reg, result;
    logic       out_valid_reg, skid_valid_reg;
    logic       accept, pop;
    logic       key_ok, sb_eff, st_eff;

    // Slider position to level.
    function automatic logic [7:0] map_slider(input logic [7:0] v, input logic log_on);
        logic [6:0]  vc;
        logic [20:0] prod;
        logic [6:0]  q;
        logic [13:0] rem;
        logic [6:0]  idx;
        vc   = (v > SLIDER_MAX) ? SLIDER_MAX[6:0] : v[6:0];
        // (vc * 90) / 127 via the reciprocal 129 / 16384 and one correction.
        prod = 21'(vc) * 21'(PCT_SPAN) * 21'd129;
        q    = prod[20:14];
        rem  = 14'(14'(vc) * 14'(PCT_SPAN)) - 14'({q, 7'd0} - 14'(q));
        if (rem >= 14'(SLIDER_MAX))
        begin
            q = q + 7'd1;
        end
        idx = PCT_LO + q;
        if (log_on)
        begin
            map_slider = PCT_LEVEL[idx];
        end
        else
        begin
            map_slider = {vc, 1'b0};
        end
    endfunction

    // Closed form of n single ramp steps on an enabled channel.
    function automatic logic [7:0] ramp_on(input logic [7:0] lvl, input logic [7:0] tgt,
                                           input logic [7:0] mn, input logic [3:0] n);
        logic [7:0] l0;
        logic [3:0] n0;
        logic [8:0] up;
        logic [8:0] room;
        logic [8:0] over;
        l0   = (lvl < mn) ? mn : lvl;
        n0   = (lvl < mn) ? (n - 4'd1) : n;
        up   = 9'(l0) + 9'(n0);
        room = 9'(l0) - 9'(mn) + 9'd1;
        over = 9'(n0) - room;
        if (n == 4'd0)
        begin
            ramp_on = lvl;
        end
        else if (tgt >= mn)
        begin
            if (l0 < tgt)
            begin
                ramp_on = (up > 9'(tgt)) ? tgt : up[7:0];
            end
            else if ((l0 - tgt) <= 8'(n0))
            begin
                ramp_on = tgt;
            end
            else
            begin
                ramp_on = l0 - 8'(n0);
            end
        end
        // Target below the floor: step down to one under the floor, then alternate.
        else if (9'(n0) <= room)
        begin
            ramp_on = l0 - 8'(n0);
        end
        else
        begin
            ramp_on = over[0] ? mn : (mn - 8'd1);
        end
    endfunction

    // Closed form of n fade steps on a disabled channel.
    function automatic logic [7:0] ramp_off(input logic [7:0] lvl, input logic [7:0] mn,
                                            input logic [3:0] n);
        logic [7:0] excess;
        excess = lvl - mn;
        if (n == 4'd0)
        begin
            ramp_off = lvl;
        end
        else if (lvl <= mn)
        begin
            ramp_off = 8'd0;
        end
        else if (8'(n) <= excess)
        begin
            ramp_off = lvl - 8'(n);
        end
        else
        begin
            ramp_off = 8'd0;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic go;
        logic [2:0] tog;
        timer_b_next = in_data.slider_bottom_event ? block_ticks_reg :
                       ((timer_b_reg != 8'd0) ? (timer_b_reg - 8'd1) : 8'd0);
        timer_t_next = in_data.slider_top_event ? block_ticks_reg :
                       ((timer_t_reg != 8'd0) ? (timer_t_reg - 8'd1) : 8'd0);

        // Keys in the order top, middle, bottom; a refused turn-off cancels the event but not the toggle update.
        go  = 1'b1;
        tog = toggle_reg;
        if (in_data.key_event)
        begin
            if ((in_data.keys_pressed & KEY_TOP) != 3'd0)
            begin
                if ((tog & KEY_TOP) != 3'd0)
                begin
                    if (timer_t_next == 8'd0)
                    begin
                        tog = ((tog & KEY_BOTTOM) != 3'd0) ? (tog & ~KEY_TOP) : 3'd0;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
                else
                begin
                    tog = tog | KEY_TOP | KEY_MIDDLE;
                end
            end
            if ((in_data.keys_pressed & KEY_MIDDLE) != 3'd0)
            begin
                if ((tog & KEY_MIDDLE) != 3'd0)
                begin
                    if (timer_b_next == 8'd0 && timer_t_next == 8'd0)
                    begin
                        tog = 3'd0;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
                else
                begin
                    tog = KEY_TOP | KEY_MIDDLE | KEY_BOTTOM;
                end
            end
            if ((in_data.keys_pressed & KEY_BOTTOM) != 3'd0)
            begin
                if ((tog & KEY_BOTTOM) != 3'd0)
                begin
                    if (timer_b_next == 8'd0)
                    begin
                        tog = ((tog & KEY_TOP) != 3'd0) ? (tog & ~KEY_BOTTOM) : 3'd0;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
                else
                begin
                    tog = tog | KEY_MIDDLE | KEY_BOTTOM;
                end
            end
        end
        toggle_next = tog;
        key_ok      = in_data.key_event && go;

        // Targets follow the sliders only on an enabled channel without a key event that goes through.
        sb_eff = in_data.slider_bottom_event && !key_ok && en_b_reg;
        st_eff = in_data.slider_top_event && !key_ok && en_t_reg;
        target_b_next = sb_eff ? map_slider(in_data.slider_bottom_value, log_scale_reg)
                               : target_b_reg;
        target_t_next = st_eff ? map_slider(in_data.slider_top_value, log_scale_reg)
                               : target_t_reg;

        on_next   = on_reg;
        en_b_next = en_b_reg;
        en_t_next = en_t_reg;
        if (key_ok && (in_data.keys_pressed & KEY_TOP) != 3'd0)
        begin
            en_t_next  = tog[2];
            on_next[1] = tog[2];
        end
        if (key_ok && (in_data.keys_pressed & KEY_MIDDLE) != 3'd0)
        begin
            en_b_next = tog[1];
            en_t_next = tog[1];
            on_next   = {tog[1], tog[1]};
        end
        if (key_ok && (in_data.keys_pressed & KEY_BOTTOM) != 3'd0)
        begin
            en_b_next  = tog[0];
            on_next[0] = tog[0];
        end

        // A disabled relay opens only once the level before this ramp is zero.
        relay_next = relay_reg;
        if (en_b_next)
        begin
            relay_next[0] = 1'b1;
        end
        else if (lvl_b_reg == 8'd0)
        begin
            relay_next[0] = 1'b0;
        end
        if (en_t_next)
        begin
            relay_next[1] = 1'b1;
        end
        else if (lvl_t_reg == 8'd0)
        begin
            relay_next[1] = 1'b0;
        end

        lvl_b_next = en_b_next ?
                     ramp_on(lvl_b_reg, target_b_next, min_level_reg, ramp_steps_reg) :
                     ramp_off(lvl_b_reg, min_level_reg, ramp_steps_reg);
        lvl_t_next = en_t_next ?
                     ramp_on(lvl_t_reg, target_t_next, min_level_reg, ramp_steps_reg) :
                     ramp_off(lvl_t_reg, min_level_reg, ramp_steps_reg);

        strobe        = (send_cnt_reg == 8'd0);
        send_cnt_next = strobe ? send_period_reg : (send_cnt_reg - 8'd1);

        result.level_bottom  = lvl_b_next;
        result.level_top     = lvl_t_next;
        result.relay_bottom  = relay_next[0];
        result.relay_top     = relay_next[1];
        result.on_status     = on_next;
        result.toggle_states = toggle_next;
        result.send_strobe   = strobe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_scale_reg   <= 1'b1;
            ramp_steps_reg  <= RST_RAMP;
            block_ticks_reg <= RST_BLOCK;
            send_period_reg <= RST_SEND;
            min_level_reg   <= RST_MIN_LEVEL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOG_SCALE:   log_scale_reg   <= cfg_data[0];
                REG_RAMP_STEPS:  ramp_steps_reg  <= cfg_data[3:0];
                REG_BLOCK_TICKS: block_ticks_reg <= cfg_data;
                REG_SEND_PERIOD: send_period_reg <= cfg_data;
                REG_MIN_LEVEL:   min_level_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg   <= '0;
            timer_b_reg  <= '0;
            timer_t_reg  <= '0;
            on_reg       <= '0;
            en_b_reg     <= 1'b0;
            en_t_reg     <= 1'b0;
            target_b_reg <= LEVEL_RESET;
            target_t_reg <= LEVEL_RESET;
            lvl_b_reg    <= '0;
            lvl_t_reg    <= '0;
            relay_reg    <= '0;
            send_cnt_reg <= '0;
        end
        else if (accept)
        begin
            toggle_reg   <= toggle_next;
            timer_b_reg  <= timer_b_next;
            timer_t_reg  <= timer_t_next;
            on_reg       <= on_next;
            en_b_reg     <= en_b_next;
            en_t_reg     <= en_t_next;
            target_b_reg <= target_b_next;
            target_t_reg <= target_t_next;
            lvl_b_reg    <= lvl_b_next;
            lvl_t_reg    <= lvl_t_next;
            relay_reg    <= relay_next;
            send_cnt_reg <= send_cnt_next;
        end
    end

    // The skid entry only fills while the output entry is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

endmodule

/* sv/dcdksr_checker.sv */
// Port-level checker for the dual channel dimmer, bound to the top level.
`include "dual_channel_dimmer_key_slider_ramp_defines.svh"

module dcdksr_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input dcdksr_pkg::out_item_t out_data
);
    import dcdksr_pkg::*;

    `DCDK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")
    `DCDK_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid, "accepted item produced no result")
    `DCDK_ASSERT_IMPL(a_on_bottom_relay, out_valid && out_data.on_status[0], out_data.relay_bottom, "bottom on without relay")
    `DCDK_ASSERT_IMPL(a_relay_off_dark, out_valid && !out_data.relay_top, out_data.level_top == 8'd0, "top relay open with nonzero level")

endmodule

bind dual_channel_dimmer_key_slider_ramp dcdksr_checker u_dcdksr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
